FILE: rtl/tps_pkg.sv
// Shared constants, types and helpers for the triangle plane splitter.
package tps_pkg;

  localparam int CoordWidth    = 16;
  localparam int NumFields     = 8;
  localparam int VertsPerTri   = 3;
  localparam int TBits         = 30;
  localparam int ReduceBits    = 32;
  localparam int CfgIndexWidth = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_NORMAL_X = 3'd0,
    CFG_NORMAL_Y = 3'd1,
    CFG_NORMAL_Z = 3'd2,
    CFG_OFFSET   = 3'd3
  } cfg_index_t;

  // Sign class of the three plane distances of one triangle.
  typedef struct packed {
    logic [VertsPerTri-1:0] neg;
    logic [VertsPerTri-1:0] zero;
  } tps_sign_t;

  // Rows of the back end's vertex store that hold the cut points.
  localparam logic [2:0] RowCut0 = 3'd3;
  localparam logic [2:0] RowCut1 = 3'd4;

  function automatic logic [1:0] next_corner(logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  // Distance magnitudes are kept at least one bit above the reduce limit.
  function automatic int mag_width(int w);
    return (2 * w + 1 > ReduceBits + 1) ? 2 * w + 1 : ReduceBits + 1;
  endfunction

endpackage

FILE: rtl/tps_queue.sv
// Two-entry triangle queue between the front and back ends.
module tps_queue #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output logic [DATA_WIDTH-1:0] pop_data
);
  logic [DATA_WIDTH-1:0] ent0;
  logic [DATA_WIDTH-1:0] ent1;
  logic [1:0]            count;
  logic                  do_push;
  logic                  do_pop;
  logic                  push_to_head;

  assign push_ready   = (count != 2'd2);
  assign pop_valid    = (count != 2'd0);
  assign pop_data     = ent0;
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop_valid && pop_ready;
  assign push_to_head = do_push && (count == 2'd0 || (count == 2'd1 && do_pop));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // The head always sits in ent0.
  always_ff @(posedge clk) begin
    if (push_to_head) begin
      ent0 <= push_data;
    end else if (do_pop) begin
      ent0 <= ent1;
    end
    if (do_push && !push_to_head) begin
      ent1 <= push_data;
    end
  end
endmodule

FILE: rtl/tps_front.sv
// Front end: configuration, vertex intake, plane distance and triangle assembly.
module tps_front #(
  parameter int COORD_WIDTH = tps_pkg::CoordWidth,
  localparam int QW = 3 * tps_pkg::NumFields * COORD_WIDTH
                    + 3 * tps_pkg::mag_width(COORD_WIDTH) + $bits(tps_pkg::tps_sign_t)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [tps_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]               cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        pos_x,
  input  logic signed [COORD_WIDTH-1:0]        pos_y,
  input  logic signed [COORD_WIDTH-1:0]        pos_z,
  input  logic signed [COORD_WIDTH-1:0]        tex_u,
  input  logic signed [COORD_WIDTH-1:0]        tex_v,
  input  logic signed [COORD_WIDTH-1:0]        norm_x,
  input  logic signed [COORD_WIDTH-1:0]        norm_y,
  input  logic signed [COORD_WIDTH-1:0]        norm_z,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output logic [QW-1:0]                        push_data
);
  import tps_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int VW = NumFields * W;
  localparam int SW = 2 * W + 2;
  localparam int MW = mag_width(W);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_SUM  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state;
  logic [1:0] vertex_count;

  logic signed [W-1:0] plane_nx;
  logic signed [W-1:0] plane_ny;
  logic signed [W-1:0] plane_nz;
  logic signed [W-1:0] plane_off;

  logic [NumFields-1:0][W-1:0]   vin;
  logic signed [2*W-1:0]         prod_x;
  logic signed [2*W-1:0]         prod_y;
  logic signed [2*W-1:0]         prod_z;
  logic [VertsPerTri-1:0][VW-1:0] slot_v;
  logic [VertsPerTri-1:0][MW-1:0] slot_m;
  tps_sign_t                     slot_s;

  logic signed [SW-1:0] pdist;
  logic [SW-1:0]        dist_abs;

  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_data  = {slot_v, slot_m, slot_s};

  // Exact distance: n.p minus the offset scaled up to the normal's fraction.
  assign pdist = SW'(prod_x) + SW'(prod_y) + SW'(prod_z) - (SW'(plane_off) <<< (W - 2));
  assign dist_abs = pdist[SW-1] ? SW'(-pdist) : SW'(pdist);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_nx  <= {2'b01, {(W-2){1'b0}}};
      plane_ny  <= '0;
      plane_nz  <= '0;
      plane_off <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NORMAL_X: plane_nx  <= cfg_data;
        CFG_NORMAL_Y: plane_ny  <= cfg_data;
        CFG_NORMAL_Z: plane_nz  <= cfg_data;
        CFG_OFFSET:   plane_off <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      vertex_count <= 2'd0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            state <= F_MUL;
          end
        end
        F_MUL: state <= F_SUM;
        F_SUM: begin
          if (vertex_count == 2'd2) begin
            vertex_count <= 2'd0;
            state        <= F_PUSH;
          end else begin
            vertex_count <= vertex_count + 2'd1;
            state        <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      vin <= {norm_z, norm_y, norm_x, tex_v, tex_u, pos_z, pos_y, pos_x};
    end
    if (state == F_MUL) begin
      prod_x <= $signed(vin[0]) * plane_nx;
      prod_y <= $signed(vin[1]) * plane_ny;
      prod_z <= $signed(vin[2]) * plane_nz;
    end
    if (state == F_SUM) begin
      slot_v[vertex_count]      <= vin;
      slot_m[vertex_count]      <= MW'(dist_abs);
      slot_s.neg[vertex_count]  <= pdist[SW-1];
      slot_s.zero[vertex_count] <= (pdist == '0);
    end
  end
endmodule

FILE: rtl/tps_back.sv
// Back end: case selection, cut parameter division, interpolation and vertex output.
module tps_back #(
  parameter int COORD_WIDTH = tps_pkg::CoordWidth,
  localparam int QW = 3 * tps_pkg::NumFields * COORD_WIDTH
                    + 3 * tps_pkg::mag_width(COORD_WIDTH) + $bits(tps_pkg::tps_sign_t)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [QW-1:0]                 q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          side,
  output logic                          last_of_run,
  output logic signed [COORD_WIDTH-1:0] out_pos_x,
  output logic signed [COORD_WIDTH-1:0] out_pos_y,
  output logic signed [COORD_WIDTH-1:0] out_pos_z,
  output logic signed [COORD_WIDTH-1:0] out_tex_u,
  output logic signed [COORD_WIDTH-1:0] out_tex_v,
  output logic signed [COORD_WIDTH-1:0] out_norm_x,
  output logic signed [COORD_WIDTH-1:0] out_norm_y,
  output logic signed [COORD_WIDTH-1:0] out_norm_z
);
  import tps_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int VW = NumFields * W;
  localparam int MW = mag_width(W);
  localparam int SB = $bits(tps_sign_t);
  localparam int PW = W + TBits + 2;
  localparam int RW = W + 3;
  localparam int IW = $clog2(TBits);
  localparam int RB = ReduceBits;
  localparam logic signed [RW-1:0] FMax = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [RW-1:0] FMin = {4'b1111, {(W-1){1'b0}}};

  typedef enum logic [7:0] {
    B_IDLE  = 8'b00000001,
    B_COPY  = 8'b00000010,
    B_SHIFT = 8'b00000100,
    B_DIV   = 8'b00001000,
    B_LMUL  = 8'b00010000,
    B_LADD  = 8'b00100000,
    B_ERD   = 8'b01000000,
    B_EWR   = 8'b10000000
  } bstate_t;

  bstate_t state;

  // Incoming triangle, unpacked.
  tps_sign_t                       qs;
  logic [VertsPerTri-1:0][MW-1:0]  qm;
  logic [VertsPerTri-1:0][VW-1:0]  qv;
  assign qs = q_data[SB-1:0];
  assign qm = q_data[SB +: VertsPerTri*MW];
  assign qv = q_data[SB + VertsPerTri*MW +: VertsPerTri*VW];

  // Case selection results.
  logic [8:0][2:0] lidx_n;
  logic [8:0]      lside_n;
  logic [3:0]      lcnt_n;
  logic [1:0]      ncut_n;
  logic [1:0]      ca_n, cb0_n, cb1_n;

  always_comb begin
    logic [VertsPerTri-1:0] pos;
    logic [1:0] npos, nneg, ip, ineg, iz, s, s1, s2;
    logic first, lone;
    pos     = ~qs.neg & ~qs.zero;
    npos    = {1'b0, pos[0]} + {1'b0, pos[1]} + {1'b0, pos[2]};
    nneg    = {1'b0, qs.neg[0]} + {1'b0, qs.neg[1]} + {1'b0, qs.neg[2]};
    ip      = pos[0] ? 2'd0 : (pos[1] ? 2'd1 : 2'd2);
    ineg    = qs.neg[0] ? 2'd0 : (qs.neg[1] ? 2'd1 : 2'd2);
    iz      = qs.zero[2] ? 2'd2 : (qs.zero[1] ? 2'd1 : 2'd0);
    s       = (nneg == 2'd1) ? ineg : ip;
    s1      = next_corner(s);
    s2      = next_corner(s1);
    lone    = (nneg == 2'd1);
    first   = (next_corner(iz) != ip);
    lidx_n  = '0;
    lside_n = '0;
    lcnt_n  = 4'd3;
    ncut_n  = 2'd0;
    ca_n    = 2'd0;
    cb0_n   = 2'd0;
    cb1_n   = 2'd0;
    if (nneg == 2'd0 || npos == 2'd0) begin
      lidx_n[0] = 3'd0;
      lidx_n[1] = 3'd1;
      lidx_n[2] = 3'd2;
      lside_n   = {9{nneg != 2'd0}};
    end else if (npos == nneg) begin
      // One corner on the plane: a single cut on the crossing edge.
      ncut_n    = 2'd1;
      ca_n      = ineg;
      cb0_n     = ip;
      lcnt_n    = 4'd6;
      lidx_n[0] = {1'b0, iz};
      lidx_n[1] = {1'b0, next_corner(iz)};
      lidx_n[2] = RowCut0;
      lidx_n[3] = RowCut0;
      lidx_n[4] = {1'b0, next_corner(next_corner(iz))};
      lidx_n[5] = {1'b0, iz};
      lside_n   = {3'b000, {3{~first}}, {3{first}}};
    end else begin
      // Lone corner: cuts on both of its edges.
      ncut_n    = 2'd2;
      ca_n      = s;
      cb0_n     = s1;
      cb1_n     = s2;
      lcnt_n    = 4'd9;
      lidx_n[0] = RowCut0;
      lidx_n[1] = RowCut1;
      lidx_n[2] = {1'b0, s};
      lidx_n[3] = RowCut0;
      lidx_n[4] = {1'b0, s1};
      lidx_n[5] = {1'b0, s2};
      lidx_n[6] = {1'b0, s2};
      lidx_n[7] = RowCut1;
      lidx_n[8] = RowCut0;
      lside_n   = {{6{~lone}}, {3{lone}}};
    end
  end

  // Working registers.
  logic [8:0][2:0]               lidx;
  logic [8:0]                    lside;
  logic [3:0]                    lcnt;
  logic [1:0]                    ncut;
  logic [1:0]                    ca, cb0, cb1;
  logic [MW-1:0]                 ma, mb0, mb1;
  logic [VertsPerTri-1:0][VW-1:0] ld_rows;
  logic [1:0]                    copy_cnt;
  logic                          cut_sel;
  logic [MW-1:0]                 a_r, b_r;
  logic [RB:0]                   dvsr;
  logic [RB+1:0]                 rem;
  logic [TBits:0]                t;
  logic [IW-1:0]                 iter;
  logic [2:0]                    fld;
  logic [3:0]                    k;
  logic [PW-1:0]                 prod;
  logic signed [W-1:0]           x1_r;
  logic                          dneg;
  logic [NumFields-1:0][W-1:0]   cut_row;
  logic [NumFields-1:0][W-1:0]   row_next;

  // Vertex store: three corners and two cut points.
  logic [VW-1:0]               pts [5];
  logic                        mem_we;
  logic [2:0]                  mem_waddr;
  logic [VW-1:0]               mem_wdata;
  logic [2:0]                  rd_a_addr, rd_b_addr;
  logic [NumFields-1:0][W-1:0] rd_a_data, rd_b_data;

  logic                too_wide;
  logic [RB+1:0]       rem2;
  logic                ge;
  logic signed [W-1:0] x1, x2;
  logic signed [W:0]   diff;
  logic [W:0]          dmag;
  logic [PW-1:0]       rsum;
  logic [W+1:0]        qv_l;
  logic signed [RW-1:0] rval;
  logic [W-1:0]        rsat;
  logic                last_cut;
  logic                emit_load;
  logic                emit_last;

  assign q_ready   = (state == B_IDLE);
  assign too_wide  = |a_r[MW-1:RB] || |b_r[MW-1:RB];
  assign rem2      = {rem[RB:0], 1'b0};
  assign ge        = (rem2 >= {1'b0, dvsr});
  assign x1        = $signed(rd_a_data[fld]);
  assign x2        = $signed(rd_b_data[fld]);
  assign diff      = {x2[W-1], x2} - {x1[W-1], x1};
  assign dmag      = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
  assign rsum      = prod + (PW'(1) << (TBits - 1));
  assign qv_l      = rsum[PW-1:TBits];
  assign rval      = dneg ? (RW'(x1_r) - $signed(RW'(qv_l)))
                          : (RW'(x1_r) + $signed(RW'(qv_l)));
  assign rsat      = (rval > FMax) ? FMax[W-1:0]
                   : (rval < FMin) ? FMin[W-1:0] : rval[W-1:0];
  assign last_cut  = (ncut == 2'd1) || cut_sel;
  assign emit_load = (state == B_EWR) && (!out_valid || out_ready);
  assign emit_last = (k == lcnt - 4'd1);

  always_comb begin
    row_next      = cut_row;
    row_next[fld] = rsat;
  end

  assign mem_we    = (state == B_COPY) || (state == B_LADD && fld == 3'd7);
  assign mem_waddr = (state == B_COPY) ? {1'b0, copy_cnt} : (cut_sel ? RowCut1 : RowCut0);
  assign mem_wdata = (state == B_COPY) ? ld_rows[0] : row_next;
  assign rd_a_addr = (state == B_ERD || state == B_EWR) ? lidx[k] : {1'b0, ca};
  assign rd_b_addr = {1'b0, cut_sel ? cb1 : cb0};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pts[mem_waddr] <= mem_wdata;
    end
    rd_a_data <= pts[rd_a_addr];
    rd_b_data <= pts[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      copy_cnt  <= 2'd0;
      cut_sel   <= 1'b0;
      iter      <= '0;
      fld       <= 3'd0;
      k         <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            copy_cnt <= 2'd0;
            state    <= B_COPY;
          end
        end
        B_COPY: begin
          copy_cnt <= copy_cnt + 2'd1;
          if (copy_cnt == 2'd2) begin
            k       <= 4'd0;
            cut_sel <= 1'b0;
            state   <= (ncut == 2'd0) ? B_ERD : B_SHIFT;
          end
        end
        B_SHIFT: begin
          if (!too_wide) begin
            iter  <= '0;
            fld   <= 3'd0;
            state <= (b_r == '0) ? B_LMUL : B_DIV;
          end
        end
        B_DIV: begin
          iter <= iter + IW'(1);
          if (iter == IW'(TBits - 1)) begin
            state <= B_LMUL;
          end
        end
        B_LMUL: state <= B_LADD;
        B_LADD: begin
          if (fld == 3'd7) begin
            if (last_cut) begin
              k     <= 4'd0;
              state <= B_ERD;
            end else begin
              cut_sel <= 1'b1;
              state   <= B_SHIFT;
            end
          end else begin
            fld   <= fld + 3'd1;
            state <= B_LMUL;
          end
        end
        B_ERD: state <= B_EWR;
        B_EWR: begin
          if (emit_load) begin
            k     <= k + 4'd1;
            state <= emit_last ? B_IDLE : B_ERD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          lidx    <= lidx_n;
          lside   <= lside_n;
          lcnt    <= lcnt_n;
          ncut    <= ncut_n;
          ca      <= ca_n;
          cb0     <= cb0_n;
          cb1     <= cb1_n;
          ma      <= qm[ca_n];
          mb0     <= qm[cb0_n];
          mb1     <= qm[cb1_n];
          ld_rows <= qv;
        end
      end
      B_COPY: begin
        ld_rows[0] <= ld_rows[1];
        ld_rows[1] <= ld_rows[2];
        a_r        <= ma;
        b_r        <= mb0;
      end
      B_SHIFT: begin
        // Halve both magnitudes together until each fits the divider.
        if (too_wide) begin
          a_r <= a_r >> 1;
          b_r <= b_r >> 1;
        end else begin
          t    <= (b_r == '0) ? ((TBits+1)'(1) << TBits) : '0;
          rem  <= (RB+2)'(a_r[RB-1:0]);
          dvsr <= {1'b0, a_r[RB-1:0]} + {1'b0, b_r[RB-1:0]};
        end
      end
      B_DIV: begin
        rem <= ge ? (rem2 - {1'b0, dvsr}) : rem2;
        t   <= {t[TBits-1:0], ge};
      end
      B_LMUL: begin
        prod <= PW'(dmag) * PW'(t);
        x1_r <= x1;
        dneg <= diff[W];
      end
      B_LADD: begin
        cut_row <= row_next;
        if (fld == 3'd7 && !last_cut) begin
          a_r <= ma;
          b_r <= mb1;
        end
      end
      default: ;
    endcase
    if (emit_load) begin
      side        <= lside[k];
      last_of_run <= emit_last;
      out_pos_x   <= rd_a_data[0];
      out_pos_y   <= rd_a_data[1];
      out_pos_z   <= rd_a_data[2];
      out_tex_u   <= rd_a_data[3];
      out_tex_v   <= rd_a_data[4];
      out_norm_x  <= rd_a_data[5];
      out_norm_y  <= rd_a_data[6];
      out_norm_z  <= rd_a_data[7];
    end
  end
endmodule

FILE: rtl/triangle_plane_splitter_core.sv
// Triangle plane splitter: vertex intake, triangle queue and cut/emit back end.
// Each vertex passes through the front end in order: capture, multiply, sum. After the third
// vertex the front end hands the triangle to a two-entry queue. The back end loads a triangle;
// for each cut it halves the distance magnitudes until they fit the divider, divides and
// interpolates the fields, and then it emits the output vertices one by one.
// Reset (synchronous, rst high) empties the queue, idles both ends and restores the plane.
module triangle_plane_splitter_core #(
  parameter int COORD_WIDTH = tps_pkg::CoordWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tps_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_WIDTH-1:0]     pos_x,
  input  logic signed [COORD_WIDTH-1:0]     pos_y,
  input  logic signed [COORD_WIDTH-1:0]     pos_z,
  input  logic signed [COORD_WIDTH-1:0]     tex_u,
  input  logic signed [COORD_WIDTH-1:0]     tex_v,
  input  logic signed [COORD_WIDTH-1:0]     norm_x,
  input  logic signed [COORD_WIDTH-1:0]     norm_y,
  input  logic signed [COORD_WIDTH-1:0]     norm_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              side,
  output logic                              last_of_run,
  output logic signed [COORD_WIDTH-1:0]     out_pos_x,
  output logic signed [COORD_WIDTH-1:0]     out_pos_y,
  output logic signed [COORD_WIDTH-1:0]     out_pos_z,
  output logic signed [COORD_WIDTH-1:0]     out_tex_u,
  output logic signed [COORD_WIDTH-1:0]     out_tex_v,
  output logic signed [COORD_WIDTH-1:0]     out_norm_x,
  output logic signed [COORD_WIDTH-1:0]     out_norm_y,
  output logic signed [COORD_WIDTH-1:0]     out_norm_z
);
  import tps_pkg::*;

  localparam int QW = 3 * NumFields * COORD_WIDTH + 3 * mag_width(COORD_WIDTH)
                    + $bits(tps_sign_t);

  logic          push_valid, push_ready;
  logic [QW-1:0] push_data;
  logic          qb_valid, qb_ready;
  logic [QW-1:0] qb_data;

  tps_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .pos_x, .pos_y, .pos_z, .tex_u, .tex_v, .norm_x, .norm_y, .norm_z,
    .push_valid, .push_ready, .push_data
  );

  tps_queue #(.DATA_WIDTH(QW)) u_queue (
    .clk, .rst,
    .push_valid, .push_ready, .push_data,
    .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_data(qb_data)
  );

  tps_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid, .out_ready, .side, .last_of_run,
    .out_pos_x, .out_pos_y, .out_pos_z, .out_tex_u, .out_tex_v,
    .out_norm_x, .out_norm_y, .out_norm_z
  );

  // The front end takes no vertex while a finished triangle waits for the queue.
  a_no_intake_while_pushing: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && push_valid))
    else $error("front end ready while holding a triangle");

  a_push_held: assert property (@(posedge clk) disable iff (rst)
    push_valid && !push_ready |=> push_valid)
    else $error("triangle dropped while queue full");

  // Taking a triangle always moves the back end out of its idle state.
  a_back_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    qb_valid && qb_ready |=> !qb_ready)
    else $error("back end stayed idle after taking a triangle");
endmodule

FILE: test/triangle_plane_splitter_core_tb.sv
// Testbench for the triangle plane splitter: random handshakes, plane settings and checks.
`timescale 1ns / 1ps
module triangle_plane_splitter_core_tb;
  import tps_pkg::*;

  localparam int W = CoordWidth;
  localparam int DrainCycles = 200;
  localparam int HoldCycles = 400;
  localparam int WatchLimit = 4000;

  typedef logic [NumFields-1:0][W-1:0] vertex_t;
  typedef struct packed {
    logic side;
    logic last;
    vertex_t f;
  } out_vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [W-1:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
  logic signed [W-1:0] norm_x = '0, norm_y = '0, norm_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic side, last_of_run;
  logic signed [W-1:0] out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v;
  logic signed [W-1:0] out_norm_x, out_norm_y, out_norm_z;

  triangle_plane_splitter_core DUT (.*);

  always #2 clk = ~clk;

  // Plane copy and open triangle of the predictor.
  longint plane_nx = 16384, plane_ny = 0, plane_nz = 0, plane_off = 0;
  int corner_cnt = 0;
  vertex_t held_corner [2];

  vertex_t vertex_queue [$];
  out_vertex_t expected_vertices [$];
  vertex_t cur_vertex;
  int in_gap = 0;
  int out_stall = 0;
  int hold_left = 0;
  bit hold_go = 0, hold_seen = 0, quiet = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  // Zero point of the current plane, used to put corners on the plane.
  bit zero_ok;
  logic [W-1:0] zero_x, zero_y, zero_z;

  task automatic add_vertex(vertex_t v);
    vertex_queue = {vertex_queue, v};
  endtask

  function automatic longint plane_distance(vertex_t v);
    return longint'($signed(v[0])) * plane_nx + longint'($signed(v[1])) * plane_ny
         + longint'($signed(v[2])) * plane_nz - (plane_off <<< (W - 2));
  endfunction

  function automatic longint unsigned cut_fraction(longint unsigned a, longint unsigned b);
    while (a >= 64'h1_0000_0000 || b >= 64'h1_0000_0000) begin
      a = a >> 1;
      b = b >> 1;
    end
    if (a + b == 0) return 0;
    return (a << TBits) / (a + b);
  endfunction

  function automatic vertex_t cut_point(vertex_t a, vertex_t b, longint da, longint db);
    longint unsigned t, q, mag;
    longint diff, r;
    vertex_t res;
    t = cut_fraction(da < 0 ? -da : da, db < 0 ? -db : db);
    for (int i = 0; i < NumFields; i++) begin
      diff = longint'($signed(b[i])) - longint'($signed(a[i]));
      mag = diff < 0 ? -diff : diff;
      q = (mag * t + (64'd1 << (TBits - 1))) >> TBits;
      r = diff < 0 ? longint'($signed(a[i])) - longint'(q) : longint'($signed(a[i])) + longint'(q);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      res[i] = r[W-1:0];
    end
    return res;
  endfunction

  // Adds the vertices that one accepted input vertex causes.
  task automatic predict_split(vertex_t v);
    vertex_t corner [3];
    vertex_t res [9];
    logic sides [9];
    vertex_t x1, x2;
    longint d [3];
    int npos, nneg, ip, ineg, iz, n, s, s1, s2;
    logic first, lone;
    out_vertex_t e;
    npos = 0; nneg = 0; ip = 0; ineg = 0; iz = 0; n = 0;
    if (corner_cnt < 2) begin
      held_corner[corner_cnt] = v;
      corner_cnt++;
      return;
    end
    corner_cnt = 0;
    corner[0] = held_corner[0];
    corner[1] = held_corner[1];
    corner[2] = v;
    for (int i = 0; i < 3; i++) begin
      d[i] = plane_distance(corner[i]);
      if (d[i] > 0) begin
        if (npos == 0) ip = i;
        npos++;
      end else if (d[i] < 0) begin
        if (nneg == 0) ineg = i;
        nneg++;
      end else iz = i;
    end
    if (nneg == 0 || npos == 0) begin
      for (int i = 0; i < 3; i++) begin
        res[n] = corner[i]; sides[n] = (nneg != 0); n++;
      end
    end else if (npos == nneg) begin
      first = ((iz + 1) % 3 == ip) ? 1'b0 : 1'b1;
      x1 = cut_point(corner[ineg], corner[ip], d[ineg], d[ip]);
      res[0] = corner[iz];           sides[0] = first;
      res[1] = corner[(iz + 1) % 3]; sides[1] = first;
      res[2] = x1;                   sides[2] = first;
      res[3] = x1;                   sides[3] = ~first;
      res[4] = corner[(iz + 2) % 3]; sides[4] = ~first;
      res[5] = corner[iz];           sides[5] = ~first;
      n = 6;
    end else begin
      s = (nneg == 1) ? ineg : ip;
      s1 = (s + 1) % 3;
      s2 = (s + 2) % 3;
      lone = (nneg == 1);
      x1 = cut_point(corner[s], corner[s1], d[s], d[s1]);
      x2 = cut_point(corner[s], corner[s2], d[s], d[s2]);
      res[0] = x1;         res[1] = x2;         res[2] = corner[s];
      res[3] = x1;         res[4] = corner[s1]; res[5] = corner[s2];
      res[6] = corner[s2]; res[7] = x2;         res[8] = x1;
      for (int i = 0; i < 9; i++) sides[i] = (i < 3) ? lone : ~lone;
      n = 9;
    end
    for (int i = 0; i < n; i++) begin
      e.side = sides[i];
      e.last = (i == n - 1);
      e.f = res[i];
      expected_vertices = {expected_vertices, e};
    end
  endtask

  // Sender: keeps valid and payload until the item is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_split(cur_vertex);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (vertex_queue.size() > 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 4) - 1;
            in_valid <= 1'b0;
          end else begin
            cur_vertex = vertex_queue.pop_front();
            pos_x <= cur_vertex[0]; pos_y <= cur_vertex[1]; pos_z <= cur_vertex[2];
            tex_u <= cur_vertex[3]; tex_v <= cur_vertex[4];
            norm_x <= cur_vertex[5]; norm_y <= cur_vertex[6]; norm_z <= cur_vertex[7];
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares every taken vertex and applies back-pressure.
  always @(posedge clk) begin
    out_vertex_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.side = side;
        got.last = last_of_run;
        got.f = {out_norm_z, out_norm_y, out_norm_x, out_tex_v, out_tex_u,
                 out_pos_z, out_pos_y, out_pos_x};
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected vertex: %h", got);
        end else begin
          want = expected_vertices.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected side %0b last %0b %h, got side %0b last %0b %h",
                       want.side, want.last, want.f, got.side, got.last, got.f);
          end
        end
      end
      if (hold_go && !hold_seen) begin
        hold_seen = 1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall = $urandom_range(1, 4) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(cfg_index_t idx, logic [W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_NORMAL_X: plane_nx = longint'($signed(val));
      CFG_NORMAL_Y: plane_ny = longint'($signed(val));
      CFG_NORMAL_Z: plane_nz = longint'($signed(val));
      CFG_OFFSET:   plane_off = longint'($signed(val));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_plane(logic [W-1:0] nx, logic [W-1:0] ny, logic [W-1:0] nz,
                           logic [W-1:0] off);
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
    write_reg(CFG_OFFSET, off);
  endtask

  task automatic drain;
    do @(posedge clk);
    while (vertex_queue.size() > 0 || in_valid || expected_vertices.size() > 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic vertex_t rand_vertex();
    vertex_t v;
    for (int i = 0; i < NumFields; i++) begin
      case ($urandom_range(0, 3))
        0: v[i] = W'($urandom_range(0, 255) - 128);
        1: v[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        default: v[i] = W'($urandom);
      endcase
    end
    if (zero_ok && $urandom_range(0, 4) == 0) begin
      v[0] = zero_x; v[1] = zero_y; v[2] = zero_z;
    end
    return v;
  endfunction

  // Directed vertex on the default plane, where only x picks the side.
  function automatic vertex_t at_x(logic [W-1:0] x);
    vertex_t v;
    v = rand_vertex();
    v[0] = x;
    return v;
  endfunction

  task automatic add_triangles(int count);
    repeat (3 * count) add_vertex(rand_vertex());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Default plane is x = 0.
    zero_ok = 1; zero_x = '0; zero_y = W'($urandom); zero_z = W'($urandom);
    add_vertex({8{16'h7fff}});
    add_vertex(at_x(16'd4096));
    add_vertex(at_x(16'd8192));
    add_vertex({8{16'h8000}});
    add_vertex(at_x(-16'sd4096));
    add_vertex(at_x(-16'sd1));
    // One corner on the plane, positive corner after it.
    add_vertex(at_x(16'd0));
    add_vertex(at_x(16'd4096));
    add_vertex(at_x(-16'sd4096));
    // One corner on the plane, negative corner after it.
    add_vertex(at_x(16'd0));
    add_vertex(at_x(16'h8000));
    add_vertex(at_x(16'd32767));
    // Lone negative corner, then lone positive corner.
    add_vertex(at_x(16'd4096));
    add_vertex(at_x(-16'sd8192));
    add_vertex(at_x(16'd12288));
    add_vertex(at_x(-16'sd4096));
    add_vertex(at_x(16'd20000));
    add_vertex(at_x(-16'sd30000));
    // All corners on the plane, and two on it with one off to the negative side.
    add_vertex(at_x(16'd0));
    add_vertex(at_x(16'd0));
    add_vertex(at_x(16'd0));
    add_vertex(at_x(16'd0));
    add_vertex(at_x(16'd0));
    add_vertex(at_x(-16'sd7));
    add_triangles(6);
    drain();

    zero_ok = 0;
    set_plane(16'h8000, 16'h0000, 16'h0000, 16'h7fff);
    write_reg(cfg_index_t'(3'd5), 16'h1234);
    add_triangles(8);
    drain();

    set_plane(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    add_triangles(8);
    drain();

    // Plane through the origin; the block fills while the receiver holds off.
    set_plane(W'($urandom), W'($urandom), W'($urandom), 16'h0000);
    zero_ok = 1; zero_x = '0; zero_y = '0; zero_z = '0;
    add_triangles(10);
    hold_go = 1;
    drain();

    set_plane(16'd16384, 16'h0000, 16'h0000, W'($urandom_range(0, 16383) - 8192));
    zero_x = plane_off[W-1:0]; zero_y = W'($urandom); zero_z = W'($urandom);
    add_triangles(10);
    drain();

    set_plane(16'd16384, 16'h0000, 16'h0000, 16'h0000);
    zero_x = '0;
    quiet = 1;
    add_triangles(6);
    drain();

    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: triangle_plane_splitter_core.f
rtl/tps_pkg.sv
rtl/tps_queue.sv
rtl/tps_front.sv
rtl/tps_back.sv
rtl/triangle_plane_splitter_core.sv
test/triangle_plane_splitter_core_tb.sv
